/* hw/rtl/puct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT selector package
// Shared widths, constants and the request type passed from front to back.
// ----------------------------------------------------------------------------
package puct_pkg;

  localparam int unsigned MaxActionsDefault = 512;
  localparam int unsigned GainW = 12;
  localparam logic [GainW-1:0] GainReset = 12'd256;
  localparam int unsigned NumW = 34;   // W + U, signed
  localparam int unsigned ScoreW = 48;
  localparam int unsigned BestW = 9;

  // One scored request from the front to the back.
  typedef struct packed {
    logic signed [31:0] value_sum;
    logic [15:0]        visits;
    logic [16:0]        prior;
    logic [15:0]        node_visits;
    logic               legal;
    logic               last;
  } req_t;

endpackage
`default_nettype wire

/* hw/rtl/puct_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT front
// Accepts children and pushes them into a short request queue.
// ----------------------------------------------------------------------------
module puct_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire puct_pkg::req_t    in_req_i,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i,
  output puct_pkg::req_t         q_req_o
);
  import puct_pkg::*;

  req_t   mem_q [2];
  logic   wr_q, rd_q;
  logic [1:0] cnt_q;
  logic   push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !q_pop_i) else $error("empty pop");
endmodule
`default_nettype wire

/* hw/rtl/puct_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT back
// Sequencer: square root, bonus product, signed division and running argmax.
// ----------------------------------------------------------------------------
module puct_back #(
  parameter int unsigned MaxActions = puct_pkg::MaxActionsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [puct_pkg::GainW-1:0] gain_i,
  input  wire logic                       q_valid_i,
  output logic                            q_pop_o,
  input  wire puct_pkg::req_t             q_req_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [puct_pkg::BestW-1:0]      best_action_o,
  output logic                            any_legal_o
);
  import puct_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxActions);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqrt = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StCmp  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]  st_q, st_d;
  req_t        r_q;
  logic [16:0] rem_q;       // square root remainder
  logic [15:0] root_q;
  logic [4:0]  step_q;      // square root step counter
  logic [28:0] gp_q;        // gain * prior
  logic [44:0] prod_q;
  logic        neg_q;
  logic [33:0] mag_q;       // |W+U|; its bits shift out into the remainder as quotient bits shift in
  logic [16:0] den_q;
  logic [16:0] drem_q;
  logic [5:0]  dcnt_q;
  logic [IdxW-1:0] idx_q;
  logic signed [ScoreW-1:0] best_q;
  logic [IdxW-1:0] bidx_q;
  logic        found_q;
  logic [BestW-1:0] oact_q;
  logic        olegal_q;

  // Square root: one result bit per step, two radicand bits.
  logic [31:0] rad;
  logic [17:0] trial;
  logic [18:0] remw;
  assign rad   = {r_q.node_visits, 16'd0};
  assign remw  = {rem_q, rad[31 - 2*step_q[3:0] -: 2]};
  assign trial = {root_q, 2'b01};

  // Division: restoring, one quotient bit per step.
  logic [17:0] dtry;
  assign dtry = {drem_q, mag_q[33]} - {1'b0, den_q};

  logic signed [NumW-1:0] num;
  assign num = NumW'(r_q.value_sum) + NumW'(signed'({1'b0, prod_q[44:16]}));

  logic signed [ScoreW-1:0] score;
  assign score = neg_q ? -ScoreW'(signed'({1'b0, mag_q})) : ScoreW'(signed'({1'b0, mag_q}));

  assign q_pop_o     = (st_q == StIdle) && q_valid_i;
  assign busy_o      = (st_q != StIdle) || q_valid_i;
  assign out_valid_o = (st_q == StOut);
  assign best_action_o = oact_q;
  assign any_legal_o   = olegal_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = StSqrt;
      StSqrt: if (step_q == 5'd15) st_d = StMul1;
      StMul1: st_d = StMul2;
      StMul2: st_d = StDiv;
      StDiv:  if (dcnt_q == 6'd34) st_d = StCmp;
      StCmp:  st_d = r_q.last ? StOut : StIdle;
      StOut:  if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      idx_q   <= '0;
      best_q  <= {1'b1, {(ScoreW-1){1'b0}}};
      bidx_q  <= '0;
      found_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StCmp) begin
        if (r_q.last) begin
          idx_q   <= '0;
          best_q  <= {1'b1, {(ScoreW-1){1'b0}}};
          bidx_q  <= '0;
          found_q <= 1'b0;
        end else begin
          idx_q <= (idx_q == IdxW'(MaxActions - 1)) ? '0 : idx_q + IdxW'(1);
          if (r_q.legal) begin
            found_q <= 1'b1;
            if (score > best_q) begin
              best_q <= score;
              bidx_q <= idx_q;
            end
          end
        end
      end
    end
  end

  logic legal_better;
  assign legal_better = r_q.legal && (score > best_q);

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        r_q    <= q_req_i;
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      StSqrt: begin
        step_q <= step_q + 5'd1;
        if (remw >= trial) begin
          rem_q  <= 17'(remw - trial);
          root_q <= {root_q[14:0], 1'b1};
        end else begin
          rem_q  <= 17'(remw);
          root_q <= {root_q[14:0], 1'b0};
        end
      end
      StMul1: gp_q <= 29'(gain_i) * 29'(r_q.prior);
      StMul2: begin
        prod_q <= 45'(gp_q) * 45'(root_q);
      end
      StDiv: begin
        if (dcnt_q == 6'd0) begin
          neg_q  <= num[NumW-1];
          mag_q  <= num[NumW-1] ? 34'(-num) : 34'(num);
          den_q  <= 17'(r_q.visits) + 17'd1;
          drem_q <= '0;
        end else begin
          if (!dtry[17]) begin
            drem_q <= dtry[16:0];
            mag_q  <= {mag_q[32:0], 1'b1};
          end else begin
            drem_q <= {drem_q[15:0], mag_q[33]};
            mag_q  <= {mag_q[32:0], 1'b0};
          end
        end
      end
      StCmp: begin
        oact_q   <= BestW'(legal_better ? idx_q : bidx_q);
        olegal_q <= found_q || r_q.legal;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (st_q == StDiv) dcnt_q <= (dcnt_q == 6'd34) ? '0 : dcnt_q + 6'd1;
    else dcnt_q <= '0;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut && out_stall_i) |=> st_q == StOut) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == StSqrt) else $error("pop without start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_pop_o) else $error("pop while result pending");
endmodule
`default_nettype wire

/* hw/rtl/puct_action_selector_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PUCT action selector, top level
// Scores the children of one node and returns the best legal index.
// ----------------------------------------------------------------------------
// Each child passes through the back sequencer in order: a pop, 16
// square-root steps, the gain-prior and bonus multiplies, a divider load
// and 34 restoring divide steps, and a compare; a two-entry request queue
// lets the source keep feeding meanwhile until it fills and raises
// in_stall_o. The last child of a node then offers its result in an output
// state, and that result is held until the output side takes it.
module puct_action_selector_top #(
  parameter int unsigned MaxActions = puct_pkg::MaxActionsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [puct_pkg::GainW-1:0] cpuct_gain_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [15:0]                node_visits_i,
  input  wire logic signed [31:0]         child_value_sum_i,
  input  wire logic [15:0]                child_visits_i,
  input  wire logic [16:0]                child_prior_i,
  input  wire logic                       is_legal_i,
  input  wire logic                       is_last_child_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [puct_pkg::BestW-1:0]      best_action_o,
  output logic                            any_legal_o
);
  import puct_pkg::*;

  logic [GainW-1:0] gain_q;
  req_t in_req, q_req;
  logic q_valid, q_pop, busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gain_q <= GainReset;
    else if (cfg_valid_i) gain_q <= cpuct_gain_i;
  end

  assign in_req = '{value_sum: child_value_sum_i, visits: child_visits_i,
                    prior: child_prior_i, node_visits: node_visits_i,
                    legal: is_legal_i, last: is_last_child_i};

  puct_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i(in_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  puct_back #(.MaxActions(MaxActions)) u_back (
    .clk_i, .rst_ni, .gain_i(gain_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_req_i(q_req), .busy_o(busy), .out_valid_o, .out_stall_i,
    .best_action_o, .any_legal_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without activity");
endmodule
`default_nettype wire
